[hw/rtl/hba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and constants of the hinted bitmap id allocator: default
// sizes, field widths, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package hba_pkg;

    localparam int NUM_IDS_DEF   = 1024;
    localparam int WORD_BITS_DEF = 32;

    localparam int TOP_W  = 16;
    localparam int HINT_W = 17;

    localparam logic [TOP_W-1:0] TOP_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC_Q,
        ST_CALC_R,
        ST_HINT_RD,
        ST_HINT_CHK,
        ST_SCAN,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load_req;
        logic calc_q;
        logic calc_r;
        logic hint_rd;
        logic hint_take;
        logic scan_start;
        logic scan_step;
        logic scan_take;
        logic fail;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hint_ok;
        logic hint_free;
        logic scan_hit;
        logic scan_end;
        logic out_space;
    } dp_sts_t;

endpackage
`default_nettype wire

[hw/rtl/hba_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/hba_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hba_ctrl
// Controller: sequences the bitmap clear, hint check, word scan and result
// hand-off, driving the datapath through command bits.
// ----------------------------------------------------------------------------
module hba_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hba_pkg::dp_sts_t sts,
    output hba_pkg::dp_cmd_t      cmd
);

    hba_pkg::state_t state_reg;
    hba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hba_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            hba_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = hba_pkg::ST_IDLE;
                end
            end
            hba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = hba_pkg::ST_CALC_Q;
                end
            end
            hba_pkg::ST_CALC_Q:
            begin
                if (sts.hint_ok)
                begin
                    cmd.calc_q = 1'b1;
                    state_next = hba_pkg::ST_CALC_R;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = hba_pkg::ST_SCAN;
                end
            end
            hba_pkg::ST_CALC_R:
            begin
                cmd.calc_r = 1'b1;
                state_next = hba_pkg::ST_HINT_RD;
            end
            hba_pkg::ST_HINT_RD:
            begin
                cmd.hint_rd = 1'b1;
                state_next  = hba_pkg::ST_HINT_CHK;
            end
            hba_pkg::ST_HINT_CHK:
            begin
                if (sts.hint_free)
                begin
                    cmd.hint_take = 1'b1;
                    state_next    = hba_pkg::ST_PUSH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = hba_pkg::ST_SCAN;
                end
            end
            hba_pkg::ST_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.scan_take = 1'b1;
                    state_next    = hba_pkg::ST_PUSH;
                end
                else if (sts.scan_end)
                begin
                    cmd.fail   = 1'b1;
                    state_next = hba_pkg::ST_PUSH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            hba_pkg::ST_PUSH:
            begin
                if (sts.out_space)
                begin
                    cmd.push   = 1'b1;
                    state_next = hba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/hba_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hba_dp
// Datapath: top register, hint slot split into word and bit, bitmap RAM,
// pipelined word scan with first-free search, scan pointer and output beat.
// ----------------------------------------------------------------------------
module hba_dp #(
    parameter int NUM_IDS   = hba_pkg::NUM_IDS_DEF,
    parameter int WORD_BITS = hba_pkg::WORD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [hba_pkg::TOP_W-1:0]   cfg_data,
    input  wire logic signed [hba_pkg::HINT_W-1:0] hint_type,
    input  wire hba_pkg::dp_cmd_t            cmd,
    output hba_pkg::dp_sts_t                 sts,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic                             granted,
    output logic [hba_pkg::TOP_W-1:0]        type_number
);

    localparam int NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WW        = $clog2(NUM_WORDS + 1);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_BITS;
    localparam int SHIFT     = 17;
    localparam int RECIP     = (1 << SHIFT) / WORD_BITS;

    // configuration
    logic [hba_pkg::TOP_W-1:0] top_reg;

    // hint handling
    logic [17:0]   hslot;
    logic          hint_ok_reg;
    logic [16:0]   h_reg;
    logic [AW-1:0] q_reg;
    logic [AW-1:0] hw_reg;
    logic [BW-1:0] hb_reg;
    logic [31:0]   q_prod;
    logic [31:0]   q_times_w;
    logic [31:0]   rem;

    // scan state
    logic [AW-1:0] clr_ptr_reg;
    logic [WW-1:0] nfh_word_reg;
    logic [BW-1:0] nfh_bit_reg;
    logic [WW-1:0] rd_ptr_reg;
    logic [AW-1:0] chk_ptr_reg;
    logic          chk_vld_reg;
    logic          rd_in;

    // pending result and output beat
    logic                      res_granted_reg;
    logic [AW-1:0]             res_word_reg;
    logic [BW-1:0]             res_bit_reg;
    logic                      out_valid_reg;
    logic                      out_granted_reg;
    logic [hba_pkg::TOP_W-1:0] out_type_reg;
    logic [31:0]               slot_full;

    // bitmap memory
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS-1:0] masked;
    logic [BW-1:0]        free_idx;

    hba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hslot = {2'b00, top_reg} - {hint_type[hba_pkg::HINT_W-1], hint_type};
    assign q_prod    = 32'(h_reg) * 32'(RECIP);
    assign q_times_w = 32'(q_reg) * 32'(WORD_BITS);
    assign rem       = 32'(h_reg) - q_times_w;
    assign rd_in     = (rd_ptr_reg < WW'(NUM_WORDS));

    // bits below the scan start and beyond the table count as taken
    always_comb
    begin
        masked   = ram_rdata;
        free_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if ((WW'(chk_ptr_reg) == nfh_word_reg) && (BW'(i) < nfh_bit_reg))
            begin
                masked[i] = 1'b1;
            end
            if ((chk_ptr_reg == AW'(NUM_WORDS - 1)) && (i >= LAST_BITS))
            begin
                masked[i] = 1'b1;
            end
        end
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                free_idx = BW'(i);
            end
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.clear_last = (clr_ptr_reg == AW'(NUM_WORDS - 1));
        sts.hint_ok    = hint_ok_reg;
        sts.hint_free  = !ram_rdata[hb_reg];
        sts.scan_hit   = chk_vld_reg && !(&masked);
        sts.scan_end   = !chk_vld_reg && !rd_in;
        sts.out_space  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_ptr_reg;
        ram_wdata = '0;
        if (cmd.clear_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.hint_take)
        begin
            ram_we    = 1'b1;
            ram_waddr = hw_reg;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << hb_reg);
        end
        else if (cmd.scan_take)
        begin
            ram_we    = 1'b1;
            ram_waddr = chk_ptr_reg;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << free_idx);
        end
        ram_re    = cmd.hint_rd || (cmd.scan_step && rd_in);
        ram_raddr = cmd.hint_rd ? hw_reg : rd_ptr_reg[AW-1:0];
    end

    assign slot_full = 32'(res_word_reg) * 32'(WORD_BITS) + 32'(res_bit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= hba_pkg::TOP_RESET;
            clr_ptr_reg   <= '0;
            nfh_word_reg  <= '0;
            nfh_bit_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                top_reg <= cfg_data;
            end
            if (cmd.clear_wr)
            begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
            end
            if (cmd.scan_start)
            begin
                chk_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                chk_vld_reg <= rd_in;
            end
            if (cmd.scan_take)
            begin
                if (free_idx == BW'(WORD_BITS - 1))
                begin
                    nfh_word_reg <= WW'(chk_ptr_reg) + WW'(1);
                    nfh_bit_reg  <= '0;
                end
                else
                begin
                    nfh_word_reg <= WW'(chk_ptr_reg);
                    nfh_bit_reg  <= free_idx + BW'(1);
                end
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            hint_ok_reg <= !hslot[17] && (hslot[16:0] < 17'(NUM_IDS));
            h_reg       <= hslot[16:0];
        end
        if (cmd.calc_q)
        begin
            q_reg <= q_prod[SHIFT +: AW];
        end
        // reciprocal estimate is at most one word short
        if (cmd.calc_r)
        begin
            if (rem >= 32'(WORD_BITS))
            begin
                hw_reg <= q_reg + AW'(1);
                hb_reg <= BW'(rem - 32'(WORD_BITS));
            end
            else
            begin
                hw_reg <= q_reg;
                hb_reg <= BW'(rem);
            end
        end
        if (cmd.scan_start)
        begin
            rd_ptr_reg <= nfh_word_reg;
        end
        else if (cmd.scan_step && rd_in)
        begin
            rd_ptr_reg  <= rd_ptr_reg + WW'(1);
            chk_ptr_reg <= rd_ptr_reg[AW-1:0];
        end
        if (cmd.hint_take)
        begin
            res_granted_reg <= 1'b1;
            res_word_reg    <= hw_reg;
            res_bit_reg     <= hb_reg;
        end
        else if (cmd.scan_take)
        begin
            res_granted_reg <= 1'b1;
            res_word_reg    <= chk_ptr_reg;
            res_bit_reg     <= free_idx;
        end
        else if (cmd.fail)
        begin
            res_granted_reg <= 1'b0;
        end
        if (cmd.push)
        begin
            out_granted_reg <= res_granted_reg;
            out_type_reg    <= res_granted_reg ? (top_reg - slot_full[hba_pkg::TOP_W-1:0])
                                               : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign granted     = out_granted_reg;
    assign type_number = out_type_reg;

endmodule
`default_nettype wire

[hw/rtl/hinted_bitmap_id_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hinted_bitmap_id_allocator_core
// Hands out unique type numbers counting down from a programmable top value,
// trying the hinted slot first and otherwise scanning a bitmap for a free one.
// ----------------------------------------------------------------------------
// After reset the bitmap RAM is cleared one word per cycle, NUM_IDS/WORD_BITS
// words (rounded up, 32 at the defaults), and in_ready stays low until that is
// done; cfg writes are taken at any time. One request is handled at a time. A
// hint that lands on a free slot is split into word and bit, then takes one RAM
// read and one write. Otherwise the scan reads one bitmap word per cycle
// through the single RAM read port, from the next-free word up, until a free
// bit is found or the words run out. The result sits in an output register,
// so the next request is accepted while a beat waits on out_ready.
// A full table gives granted 0 and type_number 0. Slots are never released.
module hinted_bitmap_id_allocator_core #(
    parameter int NUM_IDS   = hba_pkg::NUM_IDS_DEF,
    parameter int WORD_BITS = hba_pkg::WORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hba_pkg::TOP_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [hba_pkg::HINT_W-1:0] hint_type,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   granted,
    output logic [hba_pkg::TOP_W-1:0]              type_number
);

    hba_pkg::dp_cmd_t cmd;
    hba_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    hba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hba_dp #(
        .NUM_IDS   (NUM_IDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .hint_type   (hint_type),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .granted     (granted),
        .type_number (type_number)
    );

`ifndef SYNTH
    // one request in flight: an accepted beat closes the input until done
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a request is in flight");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !granted) |-> (type_number == '0))
        else $error("failed allocation carries a nonzero type number");

    a_take_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_take |-> (sts.scan_hit && !cmd.scan_step))
        else $error("scan slot taken without a free bit");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!$past(out_valid) || $past(1'b1)) && sts.out_space)
        else $error("result pushed over an undelivered beat");
`endif

endmodule
`default_nettype wire
